@@ design/pmvf_pkg.sv @@
// ----------------------------------------------------------------------------
// pmvf_pkg
// Shared widths, register indexes and mode codes for the voxel fill unit.
// ----------------------------------------------------------------------------
package pmvf_pkg;

  localparam int PhasesDef     = 4;
  localparam int ComponentsDef = 2;
  localparam int PhiIn         = 4;
  localparam int ConIn         = 2;
  localparam int FracW         = 16;
  localparam int TempW         = 20;
  localparam int SumW          = 18;
  localparam int DenW          = 19;
  localparam int NumW          = 40;
  localparam int IdxW          = 3;
  localparam int CfgW          = 20;
  localparam int DivSteps      = 4;

  localparam logic [FracW-1:0] HalfQ15 = 16'd16384;

  typedef enum logic [1:0] {
    MODE_BULK   = 2'd0,
    MODE_IFACE  = 2'd1,
    MODE_HALF   = 2'd2,
    MODE_INTERP = 2'd3
  } fill_mode_t;

  localparam logic [IdxW-1:0] REG_TARGET_MASK = 3'd0;
  localparam logic [IdxW-1:0] REG_FILL_MODE   = 3'd1;
  localparam logic [IdxW-1:0] REG_ENABLE_MASK = 3'd2;
  localparam logic [IdxW-1:0] REG_CON_FILL_0  = 3'd3;
  localparam logic [IdxW-1:0] REG_CON_FILL_1  = 3'd4;
  localparam logic [IdxW-1:0] REG_TEMP_FILL   = 3'd5;
  localparam logic [IdxW-1:0] REG_IFACE_THR   = 3'd6;
  localparam logic [IdxW-1:0] REG_BULK_THR    = 3'd7;

endpackage

@@ design/pmvf_div.sv @@
// ----------------------------------------------------------------------------
// pmvf_div
// Pipelined restoring divider: quotient of a 40-bit numerator by a 19-bit
// denominator, five quotient bits per stage at the default 20-bit quotient, valid travels with the data.
// ----------------------------------------------------------------------------
module pmvf_div
  import pmvf_pkg::*;
#(
  parameter int QW = TempW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [NumW-1:0]   in_num,
  input  logic [DenW-1:0]   in_den,
  output logic              out_vld,
  output logic [QW-1:0]     out_quo
);

  localparam int BitsPerStage = (QW + DivSteps - 1) / DivSteps;
  localparam int QPad         = BitsPerStage * DivSteps;

  // quotient fits QW bits because result <= max operand, so the numerator bits
  // above QPad already form a partial remainder below the denominator
  logic              vld_r [1:DivSteps];
  logic [DenW:0]     rem_r [1:DivSteps-1];
  logic [QPad-1:0]   num_r [1:DivSteps];
  logic [DenW-1:0]   den_r [1:DivSteps-1];

  for (genvar s = 0; s < DivSteps; s++) begin : g_stage
    logic            vld_in;
    logic [DenW:0]   rem_in;
    logic [QPad-1:0] num_in;
    logic [DenW-1:0] den_in;
    logic [DenW:0]   rem_nxt;
    logic [QPad-1:0] num_nxt;
    logic [DenW+1:0] trial;

    if (s == 0) begin : g_first
      assign vld_in = in_vld;
      assign rem_in = (DenW+1)'(in_num >> QPad);
      assign num_in = in_num[QPad-1:0];
      assign den_in = in_den;
    end else begin : g_next
      assign vld_in = vld_r[s];
      assign rem_in = rem_r[s];
      assign num_in = num_r[s];
      assign den_in = den_r[s];
    end

    always_comb begin
      rem_nxt = rem_in;
      num_nxt = num_in;
      trial   = '0;
      for (int b = 0; b < BitsPerStage; b++) begin
        trial   = {rem_nxt, num_nxt[QPad-1]};
        num_nxt = {num_nxt[QPad-2:0], 1'b0};
        if (trial >= {2'b00, den_in}) begin
          trial      = trial - {2'b00, den_in};
          num_nxt[0] = 1'b1;
        end
        rem_nxt = trial[DenW:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_in;
      end
      num_r[s+1] <= num_nxt;
    end

    if (s < DivSteps-1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[s+1] <= rem_nxt;
        den_r[s+1] <= den_in;
      end
    end
  end

  assign out_vld = vld_r[DivSteps];
  assign out_quo = num_r[DivSteps][QW-1:0];

endmodule

@@ design/phase_masked_voxel_fill_unit.sv @@
// ----------------------------------------------------------------------------
// phase_masked_voxel_fill_unit
// Per-voxel phase-masked fill: threshold overwrite or weighted blend of the
// concentration and temperature channels.
// ----------------------------------------------------------------------------
//  channel | direction | transfer when           | payload
//  in_     | in        | start && !busy          | phi_0..3, con_in_0..1, temp_in
//  out_    | out       | out_strobe (1 cycle)    | con_out_0..1, temp_out, was_filled
//  cfg_    | in        | cfg_valid && cfg_ready  | cfg_index, cfg_data
//
//  One voxel enters per cycle; busy is tied low, the pipe never stalls.
//  Pipeline stages: sum, compare, multiply, sum+round, four divider stages.
//  The divider stages set the depth; each resolves five quotient bits.
//  Synchronous active-low reset clears valid bits and config registers; the two thresholds reset to 1.
//  The receiver cannot stall, so results leave on the strobe cycle.
// ----------------------------------------------------------------------------
module phase_masked_voxel_fill_unit
  import pmvf_pkg::*;
#(
  parameter int PHASES     = PhasesDef,
  parameter int COMPONENTS = ComponentsDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [FracW-1:0] in_phi_0,
  input  logic [FracW-1:0] in_phi_1,
  input  logic [FracW-1:0] in_phi_2,
  input  logic [FracW-1:0] in_phi_3,
  input  logic [FracW-1:0] in_con_in_0,
  input  logic [FracW-1:0] in_con_in_1,
  input  logic [TempW-1:0] in_temp_in,
  output logic             out_strobe,
  output logic [FracW-1:0] out_con_out_0,
  output logic [FracW-1:0] out_con_out_1,
  output logic [TempW-1:0] out_temp_out,
  output logic             out_was_filled,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]  cfg_data
);

  localparam int DivLat = DivSteps;

  // ---------------- configuration registers
  logic [PhiIn-1:0] target_mask_r;
  fill_mode_t       fill_mode_r;
  logic [2:0]       enable_r;
  logic [FracW-1:0] con_fill_r [ConIn];
  logic [TempW-1:0] temp_fill_r;
  logic [FracW-1:0] iface_thr_r;
  logic [FracW-1:0] bulk_thr_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_mask_r <= '0;
      fill_mode_r   <= MODE_BULK;
      enable_r      <= '0;
      con_fill_r[0] <= '0;
      con_fill_r[1] <= '0;
      temp_fill_r   <= '0;
      iface_thr_r   <= 16'd1;
      bulk_thr_r    <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET_MASK: target_mask_r <= cfg_data[PhiIn-1:0];
        REG_FILL_MODE:   fill_mode_r   <= fill_mode_t'(cfg_data[1:0]);
        REG_ENABLE_MASK: enable_r      <= cfg_data[2:0];
        REG_CON_FILL_0:  con_fill_r[0] <= cfg_data[FracW-1:0];
        REG_CON_FILL_1:  con_fill_r[1] <= cfg_data[FracW-1:0];
        REG_TEMP_FILL:   temp_fill_r   <= cfg_data[TempW-1:0];
        REG_IFACE_THR:   iface_thr_r   <= cfg_data[FracW-1:0];
        REG_BULK_THR:    bulk_thr_r    <= cfg_data[FracW-1:0];
        default: ;
      endcase
    end
  end

  // channel 0..1 = concentrations, 2 = temperature
  localparam int Ch = 3;

  // ---------------- stage 1: masked sums
  logic             s1_vld_r;
  logic [SumW-1:0]  s1_tgt_r, s1_anti_r;
  logic [TempW-1:0] s1_old_r [Ch];
  logic [SumW-1:0]  tgt_nxt, anti_nxt;
  logic [FracW-1:0] phi [PhiIn];

  assign phi[0] = in_phi_0;
  assign phi[1] = in_phi_1;
  assign phi[2] = in_phi_2;
  assign phi[3] = in_phi_3;

  always_comb begin
    tgt_nxt  = '0;
    anti_nxt = '0;
    for (int i = 0; i < PhiIn; i++) begin
      if (i < PHASES) begin
        if (target_mask_r[i]) tgt_nxt = tgt_nxt + SumW'(phi[i]);
        else                  anti_nxt = anti_nxt + SumW'(phi[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
    s1_tgt_r    <= tgt_nxt;
    s1_anti_r   <= anti_nxt;
    s1_old_r[0] <= TempW'(in_con_in_0);
    s1_old_r[1] <= TempW'(in_con_in_1);
    s1_old_r[2] <= in_temp_in;
  end

  // ---------------- stage 2: condition and channel select
  logic             hit_nxt;
  logic             s2_vld_r, s2_hit_r, s2_interp_r;
  logic [Ch-1:0]    s2_sel_r;
  logic [SumW-1:0]  s2_tgt_r, s2_anti_r;
  logic [TempW-1:0] s2_old_r [Ch];
  logic [TempW-1:0] s2_fill_r [Ch];
  logic [Ch-1:0]    sel_nxt;

  always_comb begin
    case (fill_mode_r)
      MODE_BULK:  hit_nxt = s1_tgt_r > SumW'(bulk_thr_r);
      MODE_IFACE: hit_nxt = s1_tgt_r > SumW'(iface_thr_r);
      MODE_HALF:  hit_nxt = s1_tgt_r > SumW'(HalfQ15);
      default:    hit_nxt = (s1_tgt_r >= SumW'(iface_thr_r))
                            && (s1_anti_r >= SumW'(iface_thr_r))
                            && ((s1_tgt_r | s1_anti_r) != '0);
    endcase
    for (int c = 0; c < ConIn; c++) begin
      sel_nxt[c] = hit_nxt && enable_r[c] && (c < COMPONENTS);
    end
    sel_nxt[2] = hit_nxt && enable_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_hit_r     <= hit_nxt;
    s2_interp_r  <= fill_mode_r == MODE_INTERP;
    s2_sel_r     <= sel_nxt;
    s2_tgt_r     <= s1_tgt_r;
    s2_anti_r    <= s1_anti_r;
    s2_old_r     <= s1_old_r;
    s2_fill_r[0] <= TempW'(con_fill_r[0]);
    s2_fill_r[1] <= TempW'(con_fill_r[1]);
    s2_fill_r[2] <= temp_fill_r;
  end

  // ---------------- stage 3: products (20x18 multipliers)
  logic             s3_vld_r, s3_hit_r, s3_interp_r;
  logic [Ch-1:0]    s3_sel_r;
  logic [DenW-1:0]  s3_den_r;
  logic [NumW-2:0]  s3_pf_r [Ch];
  logic [NumW-2:0]  s3_po_r [Ch];
  logic [TempW-1:0] s3_old_r [Ch];
  logic [TempW-1:0] s3_fill_r [Ch];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_hit_r    <= s2_hit_r;
    s3_interp_r <= s2_interp_r;
    s3_sel_r    <= s2_sel_r;
    s3_den_r    <= DenW'(s2_tgt_r) + DenW'(s2_anti_r);
    s3_old_r    <= s2_old_r;
    s3_fill_r   <= s2_fill_r;
    for (int c = 0; c < Ch; c++) begin
      s3_pf_r[c] <= (NumW-1)'(s2_fill_r[c] * s2_tgt_r);
      s3_po_r[c] <= (NumW-1)'(s2_old_r[c] * s2_anti_r);
    end
  end

  // ---------------- stage 4: numerator plus half denominator
  logic             s4_vld_r, s4_hit_r, s4_interp_r;
  logic [Ch-1:0]    s4_sel_r;
  logic [DenW-1:0]  s4_den_r;
  logic [NumW-1:0]  s4_num_r [Ch];
  logic [TempW-1:0] s4_old_r [Ch];
  logic [TempW-1:0] s4_fill_r [Ch];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    s4_hit_r    <= s3_hit_r;
    s4_interp_r <= s3_interp_r;
    s4_sel_r    <= s3_sel_r;
    s4_den_r    <= (s3_den_r == '0) ? DenW'(1) : s3_den_r;
    s4_old_r    <= s3_old_r;
    s4_fill_r   <= s3_fill_r;
    for (int c = 0; c < Ch; c++) begin
      s4_num_r[c] <= NumW'(s3_pf_r[c]) + NumW'(s3_po_r[c])
                     + NumW'(s3_den_r >> 1);
    end
  end

  // ---------------- divider stages, side data delayed alongside
  logic [TempW-1:0] quo [Ch];
  logic [Ch-1:0]    div_vld;

  for (genvar c = 0; c < Ch; c++) begin : g_div
    pmvf_div #(.QW(TempW)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (s4_vld_r),
      .in_num  (s4_num_r[c]),
      .in_den  (s4_den_r),
      .out_vld (div_vld[c]),
      .out_quo (quo[c])
    );
  end

  logic             d_hit_r    [DivLat];
  logic             d_interp_r [DivLat];
  logic [Ch-1:0]    d_sel_r    [DivLat];
  logic [TempW-1:0] d_old_r    [DivLat][Ch];
  logic [TempW-1:0] d_fill_r   [DivLat][Ch];

  always_ff @(posedge clk) begin
    d_hit_r[0]    <= s4_hit_r;
    d_interp_r[0] <= s4_interp_r;
    d_sel_r[0]    <= s4_sel_r;
    d_old_r[0]    <= s4_old_r;
    d_fill_r[0]   <= s4_fill_r;
    for (int k = 1; k < DivLat; k++) begin
      d_hit_r[k]    <= d_hit_r[k-1];
      d_interp_r[k] <= d_interp_r[k-1];
      d_sel_r[k]    <= d_sel_r[k-1];
      d_old_r[k]    <= d_old_r[k-1];
      d_fill_r[k]   <= d_fill_r[k-1];
    end
  end

  // ---------------- output select
  logic [TempW-1:0] res [Ch];

  always_comb begin
    for (int c = 0; c < Ch; c++) begin
      if (!d_sel_r[DivLat-1][c])      res[c] = d_old_r[DivLat-1][c];
      else if (d_interp_r[DivLat-1])  res[c] = quo[c];
      else                            res[c] = d_fill_r[DivLat-1][c];
    end
  end

  // all divider lanes advance together, so their valid bits agree
  assign out_strobe     = &div_vld;
  assign out_con_out_0  = res[0][FracW-1:0];
  assign out_con_out_1  = res[1][FracW-1:0];
  assign out_temp_out   = res[2];
  assign out_was_filled = d_hit_r[DivLat-1];

endmodule
